// ----- hdl/skt_pkg.sv -----
// Shared types, status codes and elaboration helpers for the sorted key table.
// No dependencies.
package skt_pkg;

    localparam int KEY_BYTES_DEF    = 4;
    localparam int FOOTER_BYTES_DEF = 1;
    localparam int CAPACITY_DEF     = 512;

    localparam int KEY_IN_W  = 32;
    localparam int FOOTER_W  = 8;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 10;
    localparam int FANIN     = 32;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic                op;
        logic [KEY_IN_W-1:0] key;
        logic [FOOTER_W-1:0] footer;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FOOTER_W-1:0] found_footer;
        logic [COUNT_W-1:0]  entry_count;
    } out_word_t;

    typedef struct packed {
        logic cmp;
        logic shift;
    } cell_ctrl_t;

    function automatic int level_count(int n, int l);
        int c;
        c = n;
        for (int i = 0; i < l; i++)
            c = (c + FANIN - 1) / FANIN;
        return c;
    endfunction

    function automatic int tree_levels(int n);
        int c;
        int lv;
        c  = n;
        lv = 0;
        while (c > 1) begin
            c  = (c + FANIN - 1) / FANIN;
            lv = lv + 1;
        end
        return lv;
    endfunction

    function automatic int node_offset(int n, int l);
        int s;
        s = 0;
        for (int i = 1; i < l; i++)
            s = s + level_count(n, i);
        return s;
    endfunction

    function automatic int node_total(int n);
        return node_offset(n, tree_levels(n));
    endfunction

endpackage

// ----- hdl/skt_cell.sv -----
// One slot of the sorted row: holds a key and footer, compares against the
// broadcast key and shifts up from its lower neighbor on insert. Uses skt_pkg.
module skt_cell #(
    parameter int KEY_W = 32
) (
    input  logic                        clk,
    input  skt_pkg::cell_ctrl_t         ctrl,
    input  logic                        valid,
    input  logic [KEY_W-1:0]            cmp_key,
    input  logic [KEY_W-1:0]            new_key,
    input  logic [skt_pkg::FOOTER_W-1:0] new_footer,
    input  logic                        prev_lt,
    input  logic [KEY_W-1:0]            prev_key,
    input  logic [skt_pkg::FOOTER_W-1:0] prev_footer,
    output logic                        lt,
    output logic [KEY_W-1:0]            key,
    output logic [skt_pkg::FOOTER_W-1:0] footer,
    output logic [skt_pkg::FOOTER_W:0]  leaf
);

    logic [KEY_W-1:0]             key_reg;
    logic [skt_pkg::FOOTER_W-1:0] footer_reg;
    logic                         lt_reg;
    logic                         hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.cmp)
        begin
            lt_reg  <= valid && (key_reg < cmp_key);
            hit_reg <= valid && (key_reg == cmp_key);
        end
        if (ctrl.shift && !lt_reg)
        begin
            if (prev_lt)
            begin
                key_reg    <= new_key;
                footer_reg <= new_footer;
            end
            else
            begin
                key_reg    <= prev_key;
                footer_reg <= prev_footer;
            end
        end
    end

    assign lt     = lt_reg;
    assign key    = key_reg;
    assign footer = footer_reg;
    assign leaf   = {hit_reg, hit_reg ? footer_reg : '0};

endmodule

// ----- hdl/skt_or_tree.sv -----
// OR reduction of the per-cell match words: every level but the last is
// registered, and the last level is combinational. Uses skt_pkg.
module skt_or_tree #(
    parameter int N = 512,
    parameter int W = 9
) (
    input  logic                clk,
    input  logic [N-1:0][W-1:0] leaves,
    output logic [W-1:0]        root
);

    localparam int L = skt_pkg::tree_levels(N);

    if (L == 1)
    begin : g_flat
        always_comb
        begin
            root = '0;
            for (int i = 0; i < N; i++)
                root = root | leaves[i];
        end
    end
    else
    begin : g_tree
        localparam int TOT = skt_pkg::node_total(N);
        localparam int RC  = skt_pkg::level_count(N, L - 1);
        localparam int RO  = skt_pkg::node_offset(N, L - 1);

        logic [TOT-1:0][W-1:0] node_reg;

        for (genvar l = 1; l < L; l++)
        begin : g_lvl
            localparam int CC = skt_pkg::level_count(N, l - 1);
            localparam int NC = skt_pkg::level_count(N, l);
            localparam int PO = skt_pkg::node_offset(N, l - 1);
            localparam int CO = skt_pkg::node_offset(N, l);

            for (genvar j = 0; j < NC; j++)
            begin : g_node
                logic [skt_pkg::FANIN-1:0][W-1:0] kids;
                logic [W-1:0]                     acc;

                for (genvar c = 0; c < skt_pkg::FANIN; c++)
                begin : g_kid
                    if (j * skt_pkg::FANIN + c >= CC)
                    begin : g_none
                        assign kids[c] = '0;
                    end
                    else if (l == 1)
                    begin : g_leaf
                        assign kids[c] = leaves[j * skt_pkg::FANIN + c];
                    end
                    else
                    begin : g_inner
                        assign kids[c] = node_reg[PO + j * skt_pkg::FANIN + c];
                    end
                end

                always_comb
                begin
                    acc = '0;
                    for (int c = 0; c < skt_pkg::FANIN; c++)
                        acc = acc | kids[c];
                end

                always_ff @(posedge clk)
                begin
                    node_reg[CO + j] <= acc;
                end
            end
        end

        always_comb
        begin
            root = '0;
            for (int i = 0; i < RC; i++)
                root = root | node_reg[RO + i];
        end
    end

endmodule

// ----- hdl/sorted_key_table_insert_lookup_unit.sv -----
// Sorted key table: a row of compare-and-shift cells with a registered match tree.
// Accepts a new word only while idle, once the previous result has been
// registered for output. The OR tree (fan-in 32) gathers the per-cell match
// and footer.
// Reset: occupancy and control clear at once; slot contents are not cleared.
// Uses skt_pkg, skt_cell, skt_or_tree.
module sorted_key_table_insert_lookup_unit #(
    parameter int KEY_BYTES    = skt_pkg::KEY_BYTES_DEF,
    parameter int FOOTER_BYTES = skt_pkg::FOOTER_BYTES_DEF,
    parameter int CAPACITY     = skt_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  skt_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output skt_pkg::out_word_t out_data
);

    localparam int KEY_W      = (KEY_BYTES >= 4) ? skt_pkg::KEY_IN_W : 8 * KEY_BYTES;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int LEAF_W     = skt_pkg::FOOTER_W + 1;
    localparam int REG_LEVELS = skt_pkg::tree_levels(CAPACITY) - 1;
    localparam int WAIT_W     = (REG_LEVELS > 1) ? $clog2(REG_LEVELS) : 1;
    localparam logic [skt_pkg::FOOTER_W-1:0] FOOT_MASK = (FOOTER_BYTES > 0) ? '1 : '0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_FIN
    } state_t;

    state_t                       state_reg;
    logic [WAIT_W-1:0]            wait_reg;
    logic [CNT_W-1:0]             count_reg;
    logic                         out_valid_reg;
    skt_pkg::out_word_t           out_data_reg;
    logic                         op_reg;
    logic [KEY_W-1:0]             key_reg;
    logic [skt_pkg::FOOTER_W-1:0] footer_reg;

    logic                              accept;
    logic                              out_free;
    logic                              finish;
    logic                              full;
    logic                              hit;
    logic [skt_pkg::FOOTER_W-1:0]      hit_footer;
    logic                              do_shift;
    logic [LEAF_W-1:0]                 root;
    skt_pkg::cell_ctrl_t               ctrl;
    skt_pkg::out_word_t                result;
    logic [CAPACITY-1:0]               lt_w;
    logic [CAPACITY-1:0][KEY_W-1:0]    key_w;
    logic [CAPACITY-1:0][skt_pkg::FOOTER_W-1:0] footer_w;
    logic [CAPACITY-1:0][LEAF_W-1:0]   leaf_w;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign finish    = (state_reg == S_FIN) && out_free;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign hit       = root[skt_pkg::FOOTER_W];
    assign hit_footer = root[skt_pkg::FOOTER_W-1:0];
    assign do_shift  = finish && (op_reg == skt_pkg::OP_INSERT) && !hit && !full;
    assign ctrl.cmp  = accept;
    assign ctrl.shift = do_shift;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                         p_lt;
        logic [KEY_W-1:0]             p_key;
        logic [skt_pkg::FOOTER_W-1:0] p_footer;

        if (i == 0)
        begin : g_first
            assign p_lt     = 1'b1;
            assign p_key    = '0;
            assign p_footer = '0;
        end
        else
        begin : g_next
            assign p_lt     = lt_w[i-1];
            assign p_key    = key_w[i-1];
            assign p_footer = footer_w[i-1];
        end

        skt_cell #(
            .KEY_W (KEY_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (count_reg > CNT_W'(i)),
            .cmp_key     (in_data.key[KEY_W-1:0]),
            .new_key     (key_reg),
            .new_footer  (footer_reg),
            .prev_lt     (p_lt),
            .prev_key    (p_key),
            .prev_footer (p_footer),
            .lt          (lt_w[i]),
            .key         (key_w[i]),
            .footer      (footer_w[i]),
            .leaf        (leaf_w[i])
        );
    end

    skt_or_tree #(
        .N (CAPACITY),
        .W (LEAF_W)
    ) u_tree (
        .clk    (clk),
        .leaves (leaf_w),
        .root   (root)
    );

    always_comb
    begin
        result.found_footer = '0;
        result.entry_count  = skt_pkg::COUNT_W'(count_reg);
        if (op_reg == skt_pkg::OP_INSERT)
        begin
            priority if (hit)
                result.status = skt_pkg::ST_DUPLICATE;
            else if (full)
                result.status = skt_pkg::ST_FULL;
            else
            begin
                result.status      = skt_pkg::ST_INSERTED;
                result.entry_count = skt_pkg::COUNT_W'(count_reg + 1'b1);
            end
        end
        else
        begin
            if (hit)
            begin
                result.status       = skt_pkg::ST_FOUND;
                result.found_footer = hit_footer;
            end
            else
                result.status = skt_pkg::ST_NOT_FOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        wait_reg <= WAIT_W'(REG_LEVELS - 1);
                        if (REG_LEVELS == 0)
                            state_reg <= S_FIN;
                        else
                            state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (wait_reg == '0)
                        state_reg <= S_FIN;
                    else
                        wait_reg <= wait_reg - 1'b1;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        if (do_shift)
                            count_reg <= count_reg + 1'b1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= in_data.op;
            key_reg    <= in_data.key[KEY_W-1:0];
            footer_reg <= in_data.footer & FOOT_MASK;
        end
        if (finish)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- tb/sorted_key_table_insert_lookup_unit_tb.sv -----
// Self-checking testbench for the sorted key table insert/lookup unit.
// Drives random and directed insert/lookup words, tracks the ordered table in SV.
// Depends on skt_pkg and sorted_key_table_insert_lookup_unit.
`timescale 1ns / 1ps

module sorted_key_table_insert_lookup_unit_tb;

    localparam int CAP       = skt_pkg::CAPACITY_DEF;
    localparam int KW        = skt_pkg::KEY_IN_W;
    localparam int FW        = skt_pkg::FOOTER_W;
    localparam int HOLD_LEN  = 400;
    localparam int MAX_NOTES = 10;

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    skt_pkg::in_word_t  in_data  = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    skt_pkg::out_word_t out_data;

    sorted_key_table_insert_lookup_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // shadow of the ordered table
    logic [KW-1:0] tbl_key  [CAP];
    logic [FW-1:0] tbl_foot [CAP];
    int            tbl_count = 0;

    skt_pkg::in_word_t  pend_q [$];
    skt_pkg::out_word_t exp_q  [$];

    // generator-side view of which keys went in
    bit            gen_has [logic [KW-1:0]];
    logic [KW-1:0] gen_keys [$];
    int            gen_count = 0;

    int                 mismatch_cnt = 0;
    int                 words_in;
    int                 words_out;
    int                 tx_gap;
    int                 rx_gap;
    int                 rx_pause;
    int                 hold_cnt;
    int                 hold_mark;
    bit                 tx_burst;
    bit                 rx_burst;
    skt_pkg::out_word_t exp_w;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic skt_pkg::out_word_t table_step(skt_pkg::in_word_t w);
        skt_pkg::out_word_t r;
        int                 pos;
        bit                 hit;
        pos = 0;
        while (pos < tbl_count && tbl_key[pos] < w.key)
            pos++;
        hit = (pos < tbl_count) && (tbl_key[pos] == w.key);
        r = '0;
        if (w.op == skt_pkg::OP_INSERT)
        begin
            if (hit)
                r.status = skt_pkg::ST_DUPLICATE;
            else if (tbl_count >= CAP)
                r.status = skt_pkg::ST_FULL;
            else
            begin
                for (int i = tbl_count; i > pos; i--)
                begin
                    tbl_key[i]  = tbl_key[i-1];
                    tbl_foot[i] = tbl_foot[i-1];
                end
                tbl_key[pos]  = w.key;
                tbl_foot[pos] = w.footer;
                tbl_count++;
                r.status = skt_pkg::ST_INSERTED;
            end
        end
        else
        begin
            if (hit)
            begin
                r.status       = skt_pkg::ST_FOUND;
                r.found_footer = tbl_foot[pos];
            end
            else
                r.status = skt_pkg::ST_NOT_FOUND;
        end
        r.entry_count = skt_pkg::COUNT_W'(tbl_count);
        return r;
    endfunction

    function automatic int draw_gap(bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    task automatic note_mismatch(string msg);
        if (mismatch_cnt < MAX_NOTES)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    function automatic logic [KW-1:0] known_key();
        if (gen_keys.size() == 0)
            return $urandom;
        return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
    endfunction

    function automatic logic [KW-1:0] fresh_key();
        logic [KW-1:0] k;
        case ($urandom_range(0, 9))
            0: k = $urandom_range(0, 15);
            1: k = 32'hFFFF_FFFF - $urandom_range(0, 15);
            2: k = known_key() + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic queue_word(logic op, logic [KW-1:0] key, logic [FW-1:0] foot);
        skt_pkg::in_word_t w;
        w.op     = op;
        w.key    = key;
        w.footer = foot;
        pend_q.push_back(w);
        if (op == skt_pkg::OP_INSERT && !gen_has.exists(key) && gen_count < CAP)
        begin
            gen_has[key] = 1'b1;
            gen_keys.push_back(key);
            gen_count++;
        end
    endtask

    task automatic queue_random(int n, int ins_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < ins_pct)
                queue_word(skt_pkg::OP_INSERT,
                           ($urandom_range(0, 99) < 85) ? fresh_key() : known_key(),
                           $urandom_range(0, 255));
            else
                queue_word(skt_pkg::OP_LOOKUP,
                           $urandom_range(0, 1) ? known_key() : fresh_key(),
                           $urandom_range(0, 255));
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pend_q.size() != 0 || in_valid || exp_q.size() != 0)
            @(negedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            tx_gap   <= 0;
            words_in <= 0;
            tx_burst <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                exp_q.push_back(table_step(in_data));
                words_in <= words_in + 1;
                if (words_in % 64 == 63)
                    tx_burst <= ($urandom_range(0, 3) == 0);
            end
            if (!in_valid || in_ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pend_q.size() != 0)
                begin
                    in_data  <= pend_q.pop_front();
                    in_valid <= 1'b1;
                    tx_gap   <= draw_gap(tx_burst);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, armed by accepted word count
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt  <= 0;
            hold_mark <= 300;
        end
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (words_in >= hold_mark)
        begin
            hold_cnt  <= HOLD_LEN;
            hold_mark <= hold_mark + 900;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap    <= 0;
            words_out <= 0;
            rx_burst  <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (exp_q.size() == 0)
                    note_mismatch($sformatf("unexpected word status=%0d footer=%02h count=%0d",
                                            out_data.status, out_data.found_footer,
                                            out_data.entry_count));
                else
                begin
                    exp_w = exp_q.pop_front();
                    if (out_data.status !== exp_w.status ||
                        out_data.found_footer !== exp_w.found_footer ||
                        out_data.entry_count !== exp_w.entry_count)
                        note_mismatch($sformatf(
                            {"exp status=%0d footer=%02h count=%0d, ",
                             "got status=%0d footer=%02h count=%0d"},
                            exp_w.status, exp_w.found_footer, exp_w.entry_count,
                            out_data.status, out_data.found_footer, out_data.entry_count));
                end
                words_out <= words_out + 1;
                if (words_out % 64 == 63)
                    rx_burst <= ($urandom_range(0, 3) == 0);
                rx_pause = draw_gap(rx_burst);
                rx_gap    <= rx_pause;
                out_ready <= (rx_pause == 0) && (hold_cnt == 0);
            end
            else if (rx_gap != 0)
            begin
                rx_gap    <= rx_gap - 1;
                out_ready <= (rx_gap == 1) && (hold_cnt == 0);
            end
            else
                out_ready <= (hold_cnt == 0);
        end
    end

    initial
    begin
        logic [KW-1:0] k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_word(skt_pkg::OP_LOOKUP, 32'h0000_0000, 8'hFF);
        queue_word(skt_pkg::OP_INSERT, 32'h8000_0000, 8'h5A);
        queue_word(skt_pkg::OP_INSERT, 32'h0000_0000, 8'h00);
        queue_word(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 8'hFF);
        queue_word(skt_pkg::OP_INSERT, 32'h0000_0000, 8'hFF);
        queue_word(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 8'h00);
        queue_word(skt_pkg::OP_LOOKUP, 32'h0000_0000, 8'hA5);
        queue_word(skt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 8'h00);
        queue_word(skt_pkg::OP_LOOKUP, 32'h8000_0000, 8'hFF);
        queue_word(skt_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 8'h00);
        queue_word(skt_pkg::OP_INSERT, 32'h0000_0001, 8'h01);
        queue_word(skt_pkg::OP_INSERT, 32'hFFFF_FFFE, 8'hFE);
        queue_word(skt_pkg::OP_INSERT, 32'h7FFF_FFFF, 8'h80);
        queue_word(skt_pkg::OP_INSERT, 32'h8000_0001, 8'h7F);
        queue_word(skt_pkg::OP_INSERT, 32'h5555_5555, 8'h55);
        queue_word(skt_pkg::OP_INSERT, 32'hAAAA_AAAA, 8'hAA);
        queue_word(skt_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 8'h00);
        queue_word(skt_pkg::OP_LOOKUP, 32'h8000_0001, 8'h00);
        queue_word(skt_pkg::OP_LOOKUP, 32'h0000_0001, 8'hFF);
        queue_word(skt_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 8'h00);
        queue_word(skt_pkg::OP_LOOKUP, 32'h0000_0002, 8'h00);
        queue_word(skt_pkg::OP_LOOKUP, 32'hAAAA_AAAB, 8'h00);
        wait_drained();

        @(negedge clk);
        queue_random(900, 65);
        wait_drained();

        // fill up, then duplicate, new key and a lookup of that key on a full table
        @(negedge clk);
        while (gen_count < CAP)
            queue_word(skt_pkg::OP_INSERT, fresh_key(), $urandom_range(0, 255));
        queue_word(skt_pkg::OP_INSERT, known_key(), 8'hFF);
        k = $urandom;
        while (gen_has.exists(k))
            k = $urandom;
        queue_word(skt_pkg::OP_INSERT, k, 8'h00);
        queue_word(skt_pkg::OP_LOOKUP, k, 8'h00);
        wait_drained();

        @(negedge clk);
        queue_random(580, 60);
        wait_drained();
        repeat (10) @(negedge clk);

        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
